// ===== design/char_lcd_text_and_number_writer_macros.svh =====
// assertion macros used by the character lcd writer datapath
`ifndef CHAR_LCD_TEXT_AND_NUMBER_WRITER_MACROS_SVH
`define CHAR_LCD_TEXT_AND_NUMBER_WRITER_MACROS_SVH

// condition holds at every clock edge out of reset
`define CLW_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define CLW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/clw_pkg.sv =====
// shared types and constants of the character lcd writer
package clw_pkg;

    localparam int LINE_LENGTH = 16;
    localparam int MAX_DIGITS  = 10;

    localparam int POS_W      = $clog2(2 * LINE_LENGTH + 1);
    localparam int COL_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int BASE_W     = 7;
    localparam int DMODE_W    = 2;
    localparam int MODE_W     = 2;
    localparam int VALUE_W    = 32;
    localparam int PROD_W     = 2 * VALUE_W;
    localparam int DIG_W      = 4;
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // input item kinds
    localparam logic [MODE_W-1:0] IN_MODE_CMD  = 2'd0;
    localparam logic [MODE_W-1:0] IN_MODE_CHAR = 2'd1;
    localparam logic [MODE_W-1:0] IN_MODE_NUM  = 2'd2;

    // display placement modes
    localparam logic [DMODE_W-1:0] DMODE_TWO_LINE = 2'd0;
    localparam logic [DMODE_W-1:0] DMODE_ONE_LINE = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_BASE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_OPCODE   = 2'd3;

    localparam logic [DMODE_W-1:0] DMODE_RST       = 2'd0;
    localparam logic [BASE_W-1:0]  FIRST_BASE_RST  = 7'd0;
    localparam logic [BASE_W-1:0]  SECOND_BASE_RST = 7'd64;
    localparam logic [BYTE_W-1:0]  OPCODE_RST      = 8'd128;

    localparam logic [BYTE_W-1:0] CLEAR_CMD  = 8'h01;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;

    // floor(n / 10) = (n * RECIP_TEN) >> RECIP_SHIFT for any 32-bit n
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    typedef enum logic [1:0] {
        SRC_CMD,
        SRC_HOME,
        SRC_ADDR,
        SRC_CHAR
    } emit_src_t;

    typedef enum logic [2:0] {
        PK_NONE,
        PK_TWO_FIRST,
        PK_TWO_SECOND,
        PK_TWO_WRAP,
        PK_ONE_WRITE,
        PK_ONE_WRAP
    } place_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CMD,
        ST_HOME,
        ST_CONV_MUL,
        ST_CONV_DIV,
        ST_PLACE,
        ST_PLACE_DATA,
        ST_NEXT,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        emit_src_t src;
        logic      advance;
        logic      wrap;
        logic      conv_mul;
        logic      conv_div;
        logic      dig_dec;
        logic      finish;
    } clw_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        place_kind_t       kind;
        logic              write_ok;
        logic              is_clear;
        logic              conv_done;
        logic              dig_first;
    } clw_status_t;

endpackage

// ===== design/clw_ctrl.sv =====
// sequencer that steps one input item through its bus writes
module clw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  clw_pkg::clw_status_t status,
    output clw_pkg::clw_cmd_t    cmd
);
    import clw_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.src    = SRC_CMD;
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (status.mode)
                    IN_MODE_CMD:  state_next = ST_CMD;
                    IN_MODE_CHAR: state_next = ST_PLACE;
                    IN_MODE_NUM:  state_next = ST_CONV_MUL;
                    default:      state_next = ST_FINISH;
                endcase
            end
            ST_CMD: begin
                if (status.write_ok) begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_CMD;
                    state_next = status.is_clear ? ST_HOME : ST_FINISH;
                end
            end
            ST_HOME: begin
                if (status.write_ok) begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_HOME;
                    state_next = ST_FINISH;
                end
            end
            ST_CONV_MUL: begin
                cmd.conv_mul = 1'b1;
                state_next   = ST_CONV_DIV;
            end
            ST_CONV_DIV: begin
                cmd.conv_div = 1'b1;
                state_next   = status.conv_done ? ST_PLACE : ST_CONV_MUL;
            end
            ST_PLACE: begin
                case (status.kind)
                    PK_TWO_FIRST, PK_TWO_SECOND: begin
                        if (status.write_ok) begin
                            cmd.emit   = 1'b1;
                            cmd.src    = SRC_ADDR;
                            state_next = ST_PLACE_DATA;
                        end
                    end
                    PK_ONE_WRITE: begin
                        if (status.write_ok) begin
                            cmd.emit    = 1'b1;
                            cmd.src     = SRC_CHAR;
                            cmd.advance = 1'b1;
                            state_next  = ST_NEXT;
                        end
                    end
                    PK_TWO_WRAP, PK_ONE_WRAP: begin
                        // full display, or a nul in one-line placement: counters restart, character dropped
                        cmd.wrap   = 1'b1;
                        state_next = ST_NEXT;
                    end
                    default: begin
                        state_next = ST_NEXT;
                    end
                endcase
            end
            ST_PLACE_DATA: begin
                if (status.write_ok) begin
                    cmd.emit    = 1'b1;
                    cmd.src     = SRC_CHAR;
                    cmd.advance = 1'b1;
                    state_next  = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (status.mode == IN_MODE_NUM && !status.dig_first) begin
                    cmd.dig_dec = 1'b1;
                    state_next  = ST_PLACE;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.write_ok) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/clw_datapath.sv =====
// registers, placement counters, decimal conversion and output staging
`include "char_lcd_text_and_number_writer_macros.svh"

module clw_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [clw_pkg::MODE_W-1:0]    s_tuser,
    input  logic [clw_pkg::VALUE_W-1:0]   s_tdata,
    input  logic                          cfg_wr_en,
    input  logic [clw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [clw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  clw_pkg::clw_cmd_t             cmd,
    output clw_pkg::clw_status_t          status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [clw_pkg::BYTE_W-1:0]    m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import clw_pkg::*;

    logic [DMODE_W-1:0] dmode_reg;
    logic [BASE_W-1:0]  first_base_reg;
    logic [BASE_W-1:0]  second_base_reg;
    logic [BYTE_W-1:0]  opcode_reg;

    logic [MODE_W-1:0]    mode_reg;
    logic [VALUE_W-1:0]   num_reg;
    logic [PROD_W-1:0]    product_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [COL_W-1:0]     first_col_reg;
    logic [COL_W-1:0]     second_col_reg;
    logic [DIG_IDX_W-1:0] dig_idx_reg;
    logic [DIG_W-1:0]     digit_store [MAX_DIGITS];

    logic              pend_valid_reg;
    logic              pend_is_data_reg;
    logic [BYTE_W-1:0] pend_byte_reg;
    logic              out_valid_reg;
    logic              out_is_data_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic [BYTE_W-1:0]  ch;
    place_kind_t        kind;
    logic [BASE_W-1:0]  addr_base;
    logic [COL_W-1:0]   addr_col;
    logic [BYTE_W-1:0]  addr_byte;
    logic [BYTE_W-1:0]  home_byte;
    logic              new_is_data;
    logic [BYTE_W-1:0] new_byte;
    logic              write_ok;
    logic              out_load;
    logic [VALUE_W-1:0] quot;
    logic [VALUE_W-1:0] quot_x10;
    logic [DIG_W-1:0]   digit;
    logic               conv_done;

    // character being placed: input byte or next decimal digit
    assign ch = (mode_reg == IN_MODE_CHAR) ? num_reg[BYTE_W-1:0]
                : ASCII_ZERO + BYTE_W'(digit_store[dig_idx_reg]);

    always_comb begin
        case (dmode_reg)
            DMODE_TWO_LINE: begin
                if (pos_reg < POS_W'(LINE_LENGTH)) begin
                    kind = PK_TWO_FIRST;
                end else if (pos_reg < POS_W'(2 * LINE_LENGTH)) begin
                    kind = PK_TWO_SECOND;
                end else begin
                    kind = PK_TWO_WRAP;
                end
            end
            DMODE_ONE_LINE: begin
                if (pos_reg < POS_W'(LINE_LENGTH) && ch != '0) begin
                    kind = PK_ONE_WRITE;
                end else begin
                    kind = PK_ONE_WRAP;
                end
            end
            default: begin
                kind = PK_NONE;
            end
        endcase
    end

    assign addr_base = (kind == PK_TWO_SECOND) ? second_base_reg : first_base_reg;
    assign addr_col  = (kind == PK_TWO_SECOND) ? second_col_reg : first_col_reg;
    // address wraps modulo 256 before the opcode bits go on
    assign addr_byte = opcode_reg | (BYTE_W'(addr_base) + BYTE_W'(addr_col));
    assign home_byte = opcode_reg | BYTE_W'(first_base_reg);

    always_comb begin
        case (cmd.src)
            SRC_CMD: begin
                new_is_data = 1'b0;
                new_byte    = num_reg[BYTE_W-1:0];
            end
            SRC_HOME: begin
                new_is_data = 1'b0;
                new_byte    = home_byte;
            end
            SRC_ADDR: begin
                new_is_data = 1'b0;
                new_byte    = addr_byte;
            end
            default: begin
                new_is_data = 1'b1;
                new_byte    = ch;
            end
        endcase
    end

    // a write is held back one step so the final one can carry last
    assign write_ok = !pend_valid_reg || !out_valid_reg || m_tready;
    assign out_load = (cmd.emit || cmd.finish) && pend_valid_reg;

    assign quot      = VALUE_W'(product_reg[PROD_W-1:RECIP_SHIFT]);
    assign quot_x10  = (quot << 3) + (quot << 1);
    assign digit     = DIG_W'(num_reg - quot_x10);
    assign conv_done = (quot == '0) || (dig_idx_reg == DIG_IDX_W'(MAX_DIGITS - 1));

    assign status.mode      = mode_reg;
    assign status.kind      = kind;
    assign status.write_ok  = write_ok;
    assign status.is_clear  = (num_reg[BYTE_W-1:0] == CLEAR_CMD);
    assign status.conv_done = conv_done;
    assign status.dig_first = (dig_idx_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dmode_reg       <= DMODE_RST;
            first_base_reg  <= FIRST_BASE_RST;
            second_base_reg <= SECOND_BASE_RST;
            opcode_reg      <= OPCODE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DISPLAY_MODE: dmode_reg       <= cfg_wdata[DMODE_W-1:0];
                CFG_FIRST_BASE:   first_base_reg  <= cfg_wdata[BASE_W-1:0];
                CFG_SECOND_BASE:  second_base_reg <= cfg_wdata[BASE_W-1:0];
                CFG_ADDR_OPCODE:  opcode_reg      <= cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= IN_MODE_CMD;
            pos_reg        <= '0;
            first_col_reg  <= '0;
            second_col_reg <= '0;
            dig_idx_reg    <= '0;
        end else begin
            if (cmd.load) begin
                mode_reg    <= s_tuser;
                dig_idx_reg <= '0;
            end else if (cmd.conv_div) begin
                if (!conv_done) begin
                    dig_idx_reg <= dig_idx_reg + 1'b1;
                end
            end else if (cmd.dig_dec) begin
                dig_idx_reg <= dig_idx_reg - 1'b1;
            end
            if (cmd.advance) begin
                pos_reg <= pos_reg + 1'b1;
                if (kind == PK_TWO_SECOND) begin
                    second_col_reg <= second_col_reg + 1'b1;
                end else begin
                    first_col_reg <= first_col_reg + 1'b1;
                end
            end else if (cmd.wrap) begin
                pos_reg       <= '0;
                first_col_reg <= '0;
                if (kind == PK_TWO_WRAP) begin
                    second_col_reg <= '0;
                end
            end
        end
    end

    // each decimal digit takes a multiply step, then a correction step
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            num_reg <= s_tdata;
        end else if (cmd.conv_div) begin
            num_reg <= quot;
        end
        if (cmd.conv_mul) begin
            product_reg <= PROD_W'(num_reg) * PROD_W'(RECIP_TEN);
        end
        if (cmd.conv_div) begin
            digit_store[dig_idx_reg] <= digit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.emit) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.finish) begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            pend_is_data_reg <= new_is_data;
            pend_byte_reg    <= new_byte;
        end
        if (out_load) begin
            out_is_data_reg <= pend_is_data_reg;
            out_byte_reg    <= pend_byte_reg;
            out_last_reg    <= cmd.finish;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_is_data_reg;
    assign m_tlast  = out_last_reg;

    `CLW_ASSERT(a_pos_range, pos_reg <= POS_W'(2 * LINE_LENGTH), "line position past two lines")
    `CLW_ASSERT(a_first_col_range, first_col_reg <= COL_W'(LINE_LENGTH), "first column past line")
    `CLW_ASSERT(a_dig_idx_range, dig_idx_reg <= DIG_IDX_W'(MAX_DIGITS - 1), "digit index overrun")
    `CLW_ASSERT_IMP(a_write_room, cmd.emit || cmd.finish, write_ok, "write with no room")

endmodule

// ===== design/char_lcd_text_and_number_writer.sv =====
// top level of the character lcd text and number writer
// Takes one item per beat on the s_ side (tuser 0 command byte, 1 character,
// 2 unsigned number) and sends the resulting display bus writes on the m_ side,
// tuser high for a data write and tlast on the final write of the item; an
// item that causes no write sends nothing. One item is in work at a time.
// A clear command is followed by a home address write, and a character in
// two-line placement by its address write first. A number goes through a
// divide-by-ten loop, one decimal digit per pass (a 32 by 32 multiply by the
// reciprocal, then the correction), and its digits are then placed. The final
// write of an item leaves the output register in the cycle after the item ends,
// and back-pressure on m_tready can stall the writes of an item.
module char_lcd_text_and_number_writer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [clw_pkg::VALUE_W-1:0]    s_tdata,   // value
    input  logic [clw_pkg::MODE_W-1:0]     s_tuser,   // mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [clw_pkg::BYTE_W-1:0]     m_tdata,   // bus_byte
    output logic                           m_tuser,   // is_data
    output logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic [clw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import clw_pkg::*;

    clw_cmd_t    cmd;
    clw_status_t status;

    clw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    clw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== verif/char_lcd_writer_checker.sv =====
// checker for the character lcd writer: tracks settings, predicts display writes, compares
`timescale 1ns / 100ps

module char_lcd_writer_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [clw_pkg::VALUE_W-1:0]    s_tdata,   // value
    input  logic [clw_pkg::MODE_W-1:0]     s_tuser,   // mode
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [clw_pkg::BYTE_W-1:0]     m_tdata,   // bus_byte
    input  logic                           m_tuser,   // is_data
    input  logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic [clw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             mismatches,
    output int                             pending,
    output int                             writes_checked
);
    import clw_pkg::*;

    typedef struct packed {
        logic              is_data;
        logic [BYTE_W-1:0] bus_byte;
        logic              last;
    } bus_write_t;

    bus_write_t expected_writes[$];

    // shadow copy of the settings
    logic [DMODE_W-1:0] disp_mode;
    logic [BASE_W-1:0]  base_line0;
    logic [BASE_W-1:0]  base_line1;
    logic [BYTE_W-1:0]  addr_opcode;

    // cursor state
    int          line_pos;
    logic [7:0]  col_line0;
    logic [7:0]  col_line1;

    int errors = 0;
    int checked = 0;

    assign mismatches     = errors;
    assign writes_checked = checked;

    function automatic logic [BYTE_W-1:0] addr_byte(input logic [BASE_W-1:0] base,
                                                    input logic [7:0] col);
        logic [7:0] sum;
        sum = {1'b0, base} + col;
        return addr_opcode | sum;
    endfunction

    task automatic record_write(input logic data_flag, input logic [BYTE_W-1:0] b);
        bus_write_t w;
        w.is_data  = data_flag;
        w.bus_byte = b;
        w.last     = 1'b0;
        expected_writes.push_back(w);
    endtask

    task automatic place_glyph(input logic [BYTE_W-1:0] ch);
        if (disp_mode == DMODE_TWO_LINE) begin
            if (line_pos < LINE_LENGTH) begin
                record_write(1'b0, addr_byte(base_line0, col_line0));
                record_write(1'b1, ch);
                line_pos++;
                col_line0++;
            end else if (line_pos < 2 * LINE_LENGTH) begin
                record_write(1'b0, addr_byte(base_line1, col_line1));
                record_write(1'b1, ch);
                line_pos++;
                col_line1++;
            end else begin
                // both lines full: restart and drop the character
                line_pos  = 0;
                col_line0 = '0;
                col_line1 = '0;
            end
        end else if (disp_mode == DMODE_ONE_LINE) begin
            if (line_pos < LINE_LENGTH && ch != 8'h00) begin
                record_write(1'b1, ch);
                line_pos++;
                col_line0++;
            end else begin
                // nul or full line: restart, second line column kept
                line_pos  = 0;
                col_line0 = '0;
            end
        end
    endtask

    task automatic predict_item(input logic [MODE_W-1:0] kind,
                                input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] rest;
        logic [VALUE_W-1:0] rem;
        logic [DIG_W-1:0]   digits [MAX_DIGITS];
        int                 n;
        int                 first_new;
        bus_write_t         w;
        first_new = expected_writes.size();
        if (kind == IN_MODE_CMD) begin
            record_write(1'b0, value[BYTE_W-1:0]);
            if (value[BYTE_W-1:0] == CLEAR_CMD)
                record_write(1'b0, addr_byte(base_line0, 8'd0));
        end else if (kind == IN_MODE_CHAR) begin
            place_glyph(value[BYTE_W-1:0]);
        end else if (kind == IN_MODE_NUM) begin
            rest = value;
            n = 0;
            do begin
                rem = rest % 10;
                digits[n] = rem[DIG_W-1:0];
                rest = rest / 10;
                n++;
            end while (rest != 0 && n < MAX_DIGITS);
            while (n > 0) begin
                n--;
                place_glyph(ASCII_ZERO + {4'd0, digits[n]});
            end
        end
        if (expected_writes.size() > first_new) begin
            w = expected_writes.pop_back();
            w.last = 1'b1;
            expected_writes.push_back(w);
        end
    endtask

    task automatic check_write();
        bus_write_t w;
        if (expected_writes.size() == 0) begin
            errors++;
            $display("%0t: unexpected write, expected none, actual data=%0b byte=%02h last=%0b",
                     $time, m_tuser, m_tdata, m_tlast);
        end else begin
            w = expected_writes.pop_front();
            checked++;
            if (m_tuser !== w.is_data) begin
                errors++;
                $display("%0t: is_data mismatch, expected %0b, actual %0b",
                         $time, w.is_data, m_tuser);
            end
            if (m_tdata !== w.bus_byte) begin
                errors++;
                $display("%0t: bus_byte mismatch, expected %02h, actual %02h",
                         $time, w.bus_byte, m_tdata);
            end
            if (m_tlast !== w.last) begin
                errors++;
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $time, w.last, m_tlast);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            disp_mode   = DMODE_RST;
            base_line0  = FIRST_BASE_RST;
            base_line1  = SECOND_BASE_RST;
            addr_opcode = OPCODE_RST;
            line_pos    = 0;
            col_line0   = '0;
            col_line1   = '0;
            expected_writes.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DISPLAY_MODE: disp_mode   = cfg_wdata[DMODE_W-1:0];
                    CFG_FIRST_BASE:   base_line0  = cfg_wdata[BASE_W-1:0];
                    CFG_SECOND_BASE:  base_line1  = cfg_wdata[BASE_W-1:0];
                    CFG_ADDR_OPCODE:  addr_opcode = cfg_wdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_write();
        end
        pending = expected_writes.size();
    end

endmodule

// ===== verif/testbench.sv =====
// top of the character lcd writer testbench: stimulus, settings phases and verdict
`timescale 1ns / 100ps

module testbench;
    import clw_pkg::*;

    localparam logic [MODE_W-1:0]  IN_MODE_UNDEF    = 2'd3;
    localparam logic [DMODE_W-1:0] DMODE_IGNORE     = 2'd2;
    localparam logic [DMODE_W-1:0] DMODE_IGNORE_ALT = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata = '0;   // value
    logic [MODE_W-1:0]     s_tuser = '0;   // mode
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [BYTE_W-1:0]     m_tdata;        // bus_byte
    logic                  m_tuser;        // is_data
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatches;
    int pending;
    int writes_checked;

    bit                 no_idle = 1'b0;
    int                 hold_off = 0;
    int                 kind_count [4];
    int                 settings_used = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    char_lcd_text_and_number_writer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    char_lcd_writer_checker lcd_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatches     (mismatches),
        .pending        (pending),
        .writes_checked (writes_checked)
    );

    // display side stalls in bursts of random length, none while no_idle is set
    always @(posedge aclk) begin
        if (!aresetn || no_idle) begin
            hold_off <= 0;
            m_tready <= 1'b1;
        end else if (hold_off != 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            hold_off <= $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] kind, input logic [VALUE_W-1:0] value);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        kind_count[kind]++;
    endtask

    // hold the sender until every predicted write has arrived, then pad
    task automatic wait_results(input int pad);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (pad) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [DMODE_W-1:0] dm, input logic [BASE_W-1:0] b0,
                                  input logic [BASE_W-1:0] b1, input logic [BYTE_W-1:0] op);
        set_reg(CFG_DISPLAY_MODE, CFG_DATA_W'(dm));
        set_reg(CFG_FIRST_BASE, CFG_DATA_W'(b0));
        set_reg(CFG_SECOND_BASE, CFG_DATA_W'(b1));
        set_reg(CFG_ADDR_OPCODE, op);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    function automatic logic [BASE_W-1:0] pick_base();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return BASE_W'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_opcode();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_number();
        logic [VALUE_W-1:0] p;
        int                 k;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 9);
            1: return $urandom_range(10, 99999);
            2: return $urandom;
            default: begin
                // powers of ten and the all-nines just below them
                p = 1;
                k = $urandom_range(0, 9);
                repeat (k) p = p * 10;
                return ($urandom_range(0, 1) != 0) ? p : p - 1;
            end
        endcase
    endfunction

    task automatic random_item();
        int                 pick;
        logic [VALUE_W-1:0] v;
        logic [MODE_W-1:0]  kind;
        pick = $urandom_range(0, 99);
        v = $urandom;
        if (pick < 50) begin
            kind = IN_MODE_CHAR;
            if ($urandom_range(0, 9) == 0)
                v[7:0] = 8'h00;
        end else if (pick < 72) begin
            kind = IN_MODE_NUM;
            v = pick_number();
        end else if (pick < 92) begin
            kind = IN_MODE_CMD;
            if ($urandom_range(0, 4) == 0)
                v[BYTE_W-1:0] = CLEAR_CMD;
        end else begin
            kind = IN_MODE_UNDEF;
        end
        send_item(kind, v);
    endtask

    initial begin
        int                 ph;
        int                 done;
        logic [DMODE_W-1:0] dm;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // two-line placement at reset settings, filled past the end of line 1
        send_item(IN_MODE_CMD, 32'h0000_0001);
        send_item(IN_MODE_CMD, 32'hFFFF_FF01);
        send_item(IN_MODE_CMD, 32'h0000_0000);
        send_item(IN_MODE_CMD, 32'hA5A5_A5FF);
        send_item(IN_MODE_CHAR, 32'h0000_0000);
        send_item(IN_MODE_CHAR, 32'hFFFF_FFFF);
        send_item(IN_MODE_CHAR, 32'h5A5A_5A41);
        send_item(IN_MODE_NUM, 32'd0);
        send_item(IN_MODE_NUM, 32'hFFFF_FFFF);
        send_item(IN_MODE_NUM, 32'd9);
        send_item(IN_MODE_NUM, 32'd10);
        send_item(IN_MODE_NUM, 32'd1_000_000_000);
        send_item(IN_MODE_UNDEF, 32'h1234_5678);
        send_item(IN_MODE_NUM, 32'd99_999);
        send_item(IN_MODE_CHAR, 32'h0000_005A);
        send_item(IN_MODE_CHAR, 32'h0000_0061);
        wait_results(100);

        // one-line placement, bases and opcode at their top values
        apply_settings(DMODE_ONE_LINE, '1, '1, '1);
        send_item(IN_MODE_CMD, VALUE_W'(CLEAR_CMD));
        send_item(IN_MODE_CHAR, 32'hFFFF_FF00);
        send_item(IN_MODE_NUM, 32'hFFFF_FFFF);
        send_item(IN_MODE_NUM, 32'd1_234_567);
        send_item(IN_MODE_CHAR, 32'h0000_0071);
        wait_results(100);

        // characters and number digits ignored, commands still go out
        apply_settings(DMODE_IGNORE_ALT, '0, '1, '0);
        send_item(IN_MODE_CHAR, 32'h0000_0062);
        send_item(IN_MODE_NUM, 32'd42);
        send_item(IN_MODE_CMD, VALUE_W'(CLEAR_CMD));
        send_item(IN_MODE_CMD, 32'h0000_0080);
        wait_results(100);

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0, 3, 5, 7: dm = DMODE_TWO_LINE;
                1, 4:       dm = DMODE_ONE_LINE;
                2:          dm = DMODE_IGNORE;
                default:    dm = DMODE_W'($urandom_range(0, 3));
            endcase
            no_idle = (ph % 3 == 2) || (ph == 7);
            apply_settings(dm, pick_base(), pick_base(), pick_opcode());
            for (done = 0; done < 9; done++) begin
                random_item();
                if (ph == 1 && done == 4)
                    wait_results(0);
            end
            wait_results(100);
        end

        $display("sent %0d commands, %0d characters, %0d numbers, %0d undefined items",
                 kind_count[IN_MODE_CMD], kind_count[IN_MODE_CHAR],
                 kind_count[IN_MODE_NUM], kind_count[IN_MODE_UNDEF]);
        $display("under %0d register settings; %0d display writes compared",
                 settings_used, writes_checked);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
